[hw/rtl/tgeb_pkg.sv]
// Shared types and constants for the time-gap event builder.
package tgeb_pkg;

   // Detector geometry
   localparam int WORDS_PER_DETECTOR = 4;
   localparam int LABR_COUNT  = 32;
   localparam int DE_COUNT    = 64;
   localparam int E_COUNT     = 8;
   localparam int GUARD_COUNT = 8;
   localparam int PPAC_COUNT  = 4;

   // Counter layout: one counter per detector plus one for rf
   localparam int OFS_LABR  = 0;
   localparam int OFS_DE    = OFS_LABR + LABR_COUNT;
   localparam int OFS_E     = OFS_DE + DE_COUNT;
   localparam int OFS_GUARD = OFS_E + E_COUNT;
   localparam int OFS_PPAC  = OFS_GUARD + GUARD_COUNT;
   localparam int OFS_RF    = OFS_PPAC + PPAC_COUNT;
   localparam int TOTAL_COUNTERS = OFS_RF + 1;

   localparam int IDX_W = $clog2(TOTAL_COUNTERS);
   localparam int CNT_W = $clog2(WORDS_PER_DETECTOR + 1);

   // Field widths
   localparam int TS_W    = 48;
   localparam int GAP_W   = 16;
   localparam int LEN_W   = 16;
   localparam int TYPE_W  = 3;
   localparam int NUM_W   = 8;
   localparam int OUT_W   = 3;
   localparam int SLOT_W  = 4;

   localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(100);
   localparam logic [LEN_W-1:0] LEN_MAX   = '1;

   // Detector types
   localparam logic [TYPE_W-1:0] TYPE_LABR  = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_DE    = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_E     = 3'd2;
   localparam logic [TYPE_W-1:0] TYPE_GUARD = 3'd3;
   localparam logic [TYPE_W-1:0] TYPE_PPAC  = 3'd4;
   localparam logic [TYPE_W-1:0] TYPE_RF    = 3'd5;

   // Result outcome codes
   localparam logic [OUT_W-1:0] OUTCOME_STORED = 3'd0;
   localparam logic [OUT_W-1:0] OUTCOME_RANGE  = 3'd1;
   localparam logic [OUT_W-1:0] OUTCOME_FULL   = 3'd2;
   localparam logic [OUT_W-1:0] OUTCOME_IGNORE = 3'd3;
   localparam logic [OUT_W-1:0] OUTCOME_FLUSH  = 3'd4;

   // Word classification done at input
   typedef enum logic [1:0] {
      KIND_COUNT,
      KIND_RANGE,
      KIND_IGNORE
   } kind_type;

   // Counter store update from the compute stage
   typedef struct packed {
      logic             en;     // write count at idx
      logic             clr;    // new event: invalidate all counters
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] count;
   } fill_wr_type;

endpackage

[hw/rtl/tgeb_fill_store.sv]
// Per-detector fill counters: memory with valid bits and write bypass.
module tgeb_fill_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [tgeb_pkg::IDX_W-1:0]   rd_idx,
   input  logic [tgeb_pkg::IDX_W-1:0]   lk_idx,
   output logic [tgeb_pkg::CNT_W-1:0]   lk_count,
   input  tgeb_pkg::fill_wr_type        wr
);

   logic [tgeb_pkg::CNT_W-1:0] mem_ff [tgeb_pkg::TOTAL_COUNTERS];
   logic [tgeb_pkg::CNT_W-1:0] rd_data_ff;

   logic [tgeb_pkg::TOTAL_COUNTERS-1:0] valid_ff, valid_in;

   logic                       byp_vld_ff;
   logic [tgeb_pkg::IDX_W-1:0] byp_idx_ff;
   logic [tgeb_pkg::CNT_W-1:0] byp_cnt_ff;

   // Counter memory, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.idx] <= wr.count;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   // Valid bits: cleared at reset and at every event start
   always_comb begin
      valid_in = wr.clr ? '0 : valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Last write, covers a read issued on the same edge as the write
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_vld_ff <= 1'b0;
      end else if (wr.en) begin
         byp_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         byp_idx_ff <= wr.idx;
         byp_cnt_ff <= wr.count;
      end
   end

   // Current count; an invalid entry reads as zero
   always_comb begin
      if (!valid_ff[lk_idx]) begin
         lk_count = '0;
      end else if (byp_vld_ff && (byp_idx_ff == lk_idx)) begin
         lk_count = byp_cnt_ff;
      end else begin
         lk_count = rd_data_ff;
      end
   end

endmodule

[hw/rtl/time_gap_event_builder_top.sv]
// Time-gap event builder: groups timestamped detector words into events.
// A result passes the input register, then the result register, before it is valid;
// a full result register that is not being read holds the word in the input register.
// Throughput: one item per cycle while rsp_ready is held; the counter memory read is issued
// at input and a one-entry write bypass lets back-to-back words hit the same detector.
// Reset (synchronous): no event open, counters invalid, gap register 100.
module time_gap_event_builder_top (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [tgeb_pkg::GAP_W-1:0]    csr_wr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic                          req_first_of_buffer,
   input  logic [tgeb_pkg::TS_W-1:0]     req_timestamp,
   input  logic [tgeb_pkg::TYPE_W-1:0]   req_det_type,
   input  logic [tgeb_pkg::NUM_W-1:0]    req_det_number,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_starts_event,
   output logic                          rsp_closed_valid,
   output logic [tgeb_pkg::LEN_W-1:0]    rsp_closed_length,
   output logic [tgeb_pkg::OUT_W-1:0]    rsp_outcome,
   output logic [tgeb_pkg::SLOT_W-1:0]   rsp_slot_index
);

   // Configuration
   logic [tgeb_pkg::GAP_W-1:0] gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= tgeb_pkg::GAP_RESET;
      end else if (csr_wr_en) begin
         gap_ff <= csr_wr_data;
      end
   end

   // Handshake control
   logic req_xfer, s1_adv;
   logic s1_valid_ff;
   logic rsp_valid_ff;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   // Input classification: counter index and word kind
   tgeb_pkg::kind_type         s0_kind;
   logic [tgeb_pkg::IDX_W-1:0] s0_idx;

   always_comb begin
      s0_kind = tgeb_pkg::KIND_COUNT;
      s0_idx  = '0;
      unique case (req_det_type)
         tgeb_pkg::TYPE_LABR: begin
            s0_idx = tgeb_pkg::IDX_W'(tgeb_pkg::OFS_LABR + int'(req_det_number));
            if (int'(req_det_number) >= tgeb_pkg::LABR_COUNT) s0_kind = tgeb_pkg::KIND_RANGE;
         end
         tgeb_pkg::TYPE_DE: begin
            s0_idx = tgeb_pkg::IDX_W'(tgeb_pkg::OFS_DE + int'(req_det_number));
            if (int'(req_det_number) >= tgeb_pkg::DE_COUNT) s0_kind = tgeb_pkg::KIND_RANGE;
         end
         tgeb_pkg::TYPE_E: begin
            s0_idx = tgeb_pkg::IDX_W'(tgeb_pkg::OFS_E + int'(req_det_number));
            if (int'(req_det_number) >= tgeb_pkg::E_COUNT) s0_kind = tgeb_pkg::KIND_RANGE;
         end
         tgeb_pkg::TYPE_GUARD: begin
            s0_idx = tgeb_pkg::IDX_W'(tgeb_pkg::OFS_GUARD + int'(req_det_number));
            if (int'(req_det_number) >= tgeb_pkg::GUARD_COUNT) s0_kind = tgeb_pkg::KIND_RANGE;
         end
         tgeb_pkg::TYPE_PPAC: begin
            s0_idx = tgeb_pkg::IDX_W'(tgeb_pkg::OFS_PPAC + int'(req_det_number));
            if (int'(req_det_number) >= tgeb_pkg::PPAC_COUNT) s0_kind = tgeb_pkg::KIND_RANGE;
         end
         // rf has a single counter, number ignored
         tgeb_pkg::TYPE_RF: begin
            s0_idx = tgeb_pkg::IDX_W'(tgeb_pkg::OFS_RF);
         end
         default: begin
            s0_kind = tgeb_pkg::KIND_IGNORE;
         end
      endcase
   end

   // Input register
   logic                       s1_mode_ff, s1_first_ff;
   logic [tgeb_pkg::TS_W-1:0]  s1_ts_ff;
   tgeb_pkg::kind_type         s1_kind_ff;
   logic [tgeb_pkg::IDX_W-1:0] s1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_mode_ff  <= req_mode;
         s1_first_ff <= req_first_of_buffer;
         s1_ts_ff    <= req_timestamp;
         s1_kind_ff  <= s0_kind;
         s1_idx_ff   <= s0_idx;
      end
   end

   // Fill counters
   logic [tgeb_pkg::CNT_W-1:0] cnt_cur;
   tgeb_pkg::fill_wr_type      fill_wr;

   tgeb_fill_store u_fill_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_xfer),
      .rd_idx   (s0_idx),
      .lk_idx   (s1_idx_ff),
      .lk_count (cnt_cur),
      .wr       (fill_wr)
   );

   // Event state
   logic [tgeb_pkg::TS_W-1:0]  prev_ts_ff, prev_ts_in;
   logic                       open_ff, open_in;
   logic [tgeb_pkg::LEN_W-1:0] len_ff, len_in;

   // Gap decision: exact difference, a negative one never counts as a gap
   logic [tgeb_pkg::TS_W:0]    ts_diff;
   logic                       gap_hit, starts, closes, full;
   logic [tgeb_pkg::CNT_W-1:0] cnt_eff;
   logic [tgeb_pkg::OUT_W-1:0] outcome;

   assign ts_diff = {1'b0, s1_ts_ff} - {1'b0, prev_ts_ff};
   assign gap_hit = !ts_diff[tgeb_pkg::TS_W] &&
                    (ts_diff[tgeb_pkg::TS_W-1:0] > tgeb_pkg::TS_W'(gap_ff));
   assign starts  = !s1_mode_ff && (s1_first_ff || !open_ff || gap_hit);
   assign closes  = open_ff && (s1_mode_ff || starts);
   assign cnt_eff = starts ? '0 : cnt_cur;
   assign full    = cnt_eff >= tgeb_pkg::CNT_W'(tgeb_pkg::WORDS_PER_DETECTOR);

   // Outcome
   always_comb begin
      priority if (s1_mode_ff) begin
         outcome = tgeb_pkg::OUTCOME_FLUSH;
      end else if (s1_kind_ff == tgeb_pkg::KIND_IGNORE) begin
         outcome = tgeb_pkg::OUTCOME_IGNORE;
      end else if (s1_kind_ff == tgeb_pkg::KIND_RANGE) begin
         outcome = tgeb_pkg::OUTCOME_RANGE;
      end else if (full) begin
         outcome = tgeb_pkg::OUTCOME_FULL;
      end else begin
         outcome = tgeb_pkg::OUTCOME_STORED;
      end
   end

   // Counter update
   always_comb begin
      fill_wr.en    = s1_adv && (outcome == tgeb_pkg::OUTCOME_STORED);
      fill_wr.clr   = s1_adv && starts;
      fill_wr.idx   = s1_idx_ff;
      fill_wr.count = cnt_eff + 1'b1;
   end

   // Next event state
   always_comb begin
      prev_ts_in = prev_ts_ff;
      open_in    = open_ff;
      len_in     = len_ff;
      if (s1_mode_ff) begin
         open_in = 1'b0;
         len_in  = '0;
      end else begin
         prev_ts_in = s1_ts_ff;
         open_in    = 1'b1;
         if (starts) begin
            len_in = tgeb_pkg::LEN_W'(1);
         end else if (len_ff != tgeb_pkg::LEN_MAX) begin
            len_in = len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ts_ff <= '0;
         open_ff    <= 1'b0;
         len_ff     <= '0;
      end else if (s1_adv) begin
         prev_ts_ff <= prev_ts_in;
         open_ff    <= open_in;
         len_ff     <= len_in;
      end
   end

   // Result register
   logic                          rsp_starts_ff, rsp_closed_ff;
   logic [tgeb_pkg::LEN_W-1:0]    rsp_len_ff;
   logic [tgeb_pkg::OUT_W-1:0]    rsp_outcome_ff;
   logic [tgeb_pkg::SLOT_W-1:0]   rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_starts_ff  <= starts;
         rsp_closed_ff  <= closes;
         rsp_len_ff     <= closes ? len_ff : '0;
         rsp_outcome_ff <= outcome;
         rsp_slot_ff    <= (outcome == tgeb_pkg::OUTCOME_STORED) ?
                           tgeb_pkg::SLOT_W'(cnt_eff) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_starts_event  = rsp_starts_ff;
   assign rsp_closed_valid  = rsp_closed_ff;
   assign rsp_closed_length = rsp_len_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_slot_index    = rsp_slot_ff;

   // Checks
   a_slot_only_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome != tgeb_pkg::OUTCOME_STORED) |-> rsp_slot_index == '0)
      else $error("slot index set on a word that was not stored");

   a_slot_below_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == tgeb_pkg::OUTCOME_STORED) |->
      (int'(rsp_slot_index) < tgeb_pkg::WORDS_PER_DETECTOR))
      else $error("slot index beyond detector depth");

   a_len_only_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_closed_valid |-> rsp_closed_length == '0)
      else $error("closed length reported without a closed event");

   a_flush_closes: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_mode_ff |=> !open_ff && (len_ff == '0))
      else $error("event still open after flush");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      s1_adv && starts |=> open_ff && (len_ff == tgeb_pkg::LEN_W'(1)))
      else $error("event start did not open a one-word event");

endmodule

[dv/tgeb_checker.sv]
// Result checker for the time-gap event builder: tracks events and compares every result.
`timescale 1ns / 1ps

module tgeb_checker
   import tgeb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [GAP_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_mode,
   input  logic              req_first_of_buffer,
   input  logic [TS_W-1:0]   req_timestamp,
   input  logic [TYPE_W-1:0] req_det_type,
   input  logic [NUM_W-1:0]  req_det_number,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_starts_event,
   input  logic              rsp_closed_valid,
   input  logic [LEN_W-1:0]  rsp_closed_length,
   input  logic [OUT_W-1:0]  rsp_outcome,
   input  logic [SLOT_W-1:0] rsp_slot_index,
   output int                mismatch_count,
   output int                outcomes_pending
);

   typedef struct packed {
      logic              starts_event;
      logic              closed_valid;
      logic [LEN_W-1:0]  closed_length;
      logic [OUT_W-1:0]  outcome;
      logic [SLOT_W-1:0] slot_index;
   } word_outcome_type;

   // Shadow of the builder state
   logic [GAP_W-1:0] gap_shadow;
   logic [TS_W-1:0]  last_ts;
   logic             evt_open;
   logic [LEN_W-1:0] evt_len;
   int unsigned      fill_level [TOTAL_COUNTERS];
   word_outcome_type pending_outcomes [$];

   // One line per mismatch, and count it
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("tgeb_checker: %0t %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Works out the result of one transfer and advances the shadow state
   task automatic predict_word_outcome(input logic flush, input logic first,
                                       input logic [TS_W-1:0] ts,
                                       input logic [TYPE_W-1:0] kind,
                                       input logic [NUM_W-1:0] number,
                                       output word_outcome_type res);
      int base;
      int limit;
      int num;
      bit known;
      res = '0;
      base = 0;
      limit = 0;
      num = int'(number);
      known = 1'b1;
      if (flush) begin
         // close whatever is open; timestamp history is kept
         if (evt_open) begin
            res.closed_valid = 1'b1;
            res.closed_length = evt_len;
         end
         evt_open = 1'b0;
         evt_len = '0;
         res.outcome = OUTCOME_FLUSH;
      end else begin
         // forced start, nothing open, or a forward step wider than the gap
         if (first || !evt_open ||
             (ts > last_ts && (ts - last_ts) > TS_W'(gap_shadow))) begin
            res.starts_event = 1'b1;
            if (evt_open) begin
               res.closed_valid = 1'b1;
               res.closed_length = evt_len;
            end
            foreach (fill_level[i]) fill_level[i] = 0;
            evt_open = 1'b1;
            evt_len = LEN_W'(1);
         end else if (evt_len != LEN_MAX) begin
            evt_len++;
         end
         last_ts = ts;

         // detector lookup
         case (kind)
            TYPE_LABR: begin
               base = OFS_LABR;
               limit = LABR_COUNT;
            end
            TYPE_DE: begin
               base = OFS_DE;
               limit = DE_COUNT;
            end
            TYPE_E: begin
               base = OFS_E;
               limit = E_COUNT;
            end
            TYPE_GUARD: begin
               base = OFS_GUARD;
               limit = GUARD_COUNT;
            end
            TYPE_PPAC: begin
               base = OFS_PPAC;
               limit = PPAC_COUNT;
            end
            TYPE_RF: begin
               base = OFS_RF;
               limit = 1;
               num = 0;
            end
            default: known = 1'b0;
         endcase

         if (!known)
            res.outcome = OUTCOME_IGNORE;
         else if (num >= limit)
            res.outcome = OUTCOME_RANGE;
         else if (fill_level[base + num] >= WORDS_PER_DETECTOR)
            res.outcome = OUTCOME_FULL;
         else begin
            res.outcome = OUTCOME_STORED;
            res.slot_index = SLOT_W'(fill_level[base + num]);
            fill_level[base + num]++;
         end
      end
   endtask

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin : monitor
      word_outcome_type want;
      word_outcome_type got;
      if (reset) begin
         gap_shadow = GAP_RESET;
         last_ts = '0;
         evt_open = 1'b0;
         evt_len = '0;
         foreach (fill_level[i]) fill_level[i] = 0;
         pending_outcomes.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en)
            gap_shadow = csr_wr_data;

         if (req_valid && req_ready) begin
            predict_word_outcome(req_mode, req_first_of_buffer, req_timestamp,
                                 req_det_type, req_det_number, want);
            pending_outcomes.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            got = {rsp_starts_event, rsp_closed_valid, rsp_closed_length,
                   rsp_outcome, rsp_slot_index};
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with nothing expected", got, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (got.starts_event !== want.starts_event)
                  report_mismatch("starts_event", got.starts_event, want.starts_event);
               if (got.closed_valid !== want.closed_valid)
                  report_mismatch("closed_valid", got.closed_valid, want.closed_valid);
               if (got.closed_length !== want.closed_length)
                  report_mismatch("closed_length", got.closed_length, want.closed_length);
               if (got.outcome !== want.outcome)
                  report_mismatch("outcome", got.outcome, want.outcome);
               if (got.slot_index !== want.slot_index)
                  report_mismatch("slot_index", got.slot_index, want.slot_index);
            end
         end
      end
      outcomes_pending = pending_outcomes.size();
   end

endmodule

[dv/tb.sv]
// Testbench top for the time-gap event builder: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import tgeb_pkg::*;

   localparam logic              MODE_DATA   = 1'b0;
   localparam logic              MODE_FLUSH  = 1'b1;
   localparam logic [TYPE_W-1:0] TYPE_OTHER  = 3'd6;
   localparam logic [TYPE_W-1:0] TYPE_SPARE  = 3'd7;
   localparam int                QUIET_LIMIT = 2000;
   localparam int                PHASE_WORDS = 280;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [GAP_W-1:0]  csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = MODE_DATA;
   logic              req_first_of_buffer = 1'b0;
   logic [TS_W-1:0]   req_timestamp = '0;
   logic [TYPE_W-1:0] req_det_type = TYPE_LABR;
   logic [NUM_W-1:0]  req_det_number = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_starts_event;
   logic              rsp_closed_valid;
   logic [LEN_W-1:0]  rsp_closed_length;
   logic [OUT_W-1:0]  rsp_outcome;
   logic [SLOT_W-1:0] rsp_slot_index;

   int                mismatch_count;
   int                outcomes_pending;
   int                quiet_cycles = 0;
   int                rsp_hold = 0;
   bit                req_calm = 1'b0;
   bit                rsp_calm = 1'b0;
   logic [TS_W-1:0]   now_ts = '0;
   logic [GAP_W-1:0]  cur_gap = GAP_RESET;

   time_gap_event_builder_top dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_first_of_buffer (req_first_of_buffer),
      .req_timestamp       (req_timestamp),
      .req_det_type        (req_det_type),
      .req_det_number      (req_det_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_starts_event    (rsp_starts_event),
      .rsp_closed_valid    (rsp_closed_valid),
      .rsp_closed_length   (rsp_closed_length),
      .rsp_outcome         (rsp_outcome),
      .rsp_slot_index      (rsp_slot_index)
   );

   tgeb_checker outcome_check (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_first_of_buffer (req_first_of_buffer),
      .req_timestamp       (req_timestamp),
      .req_det_type        (req_det_type),
      .req_det_number      (req_det_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_starts_event    (rsp_starts_event),
      .rsp_closed_valid    (rsp_closed_valid),
      .rsp_closed_length   (rsp_closed_length),
      .rsp_outcome         (rsp_outcome),
      .rsp_slot_index      (rsp_slot_index),
      .mismatch_count      (mismatch_count),
      .outcomes_pending    (outcomes_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle length: mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      if (req_calm || $urandom_range(0, 99) < 55) return 0;
      return idle_len();
   endfunction

   function automatic int detector_count(input logic [TYPE_W-1:0] kind);
      case (kind)
         TYPE_LABR:  return LABR_COUNT;
         TYPE_DE:    return DE_COUNT;
         TYPE_E:     return E_COUNT;
         TYPE_GUARD: return GUARD_COUNT;
         TYPE_PPAC:  return PPAC_COUNT;
         TYPE_RF:    return 1;
         default:    return 0;
      endcase
   endfunction

   // Next timestamp: openers mostly jump past the gap, the rest mostly stay inside it
   function automatic logic [TS_W-1:0] next_ts(input bit opener);
      int r;
      r = $urandom_range(0, 99);
      if (opener) begin
         if (r < 80) return now_ts + cur_gap + 1 + $urandom_range(0, 500);
         return TS_W'({$urandom(), $urandom()});
      end
      if (r < 65) return now_ts + $urandom_range(0, cur_gap);
      if (r < 75) return now_ts - $urandom_range(0, 200);
      if (r < 85) return now_ts + cur_gap;
      if (r < 92) return now_ts + cur_gap + 1;
      if (r < 96) return TS_W'({$urandom(), $urandom()});
      return now_ts + cur_gap + 1 + $urandom_range(0, 100000);
   endfunction

   // Result side: random stall runs unless calm
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
         rsp_ready <= 1'b0;
         rsp_hold <= idle_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request transfer; valid holds until accepted
   task automatic send_word(input logic mode, input logic first,
                            input logic [TS_W-1:0] ts, input logic [TYPE_W-1:0] kind,
                            input logic [NUM_W-1:0] number);
      int idle;
      idle = sender_gap();
      @(negedge clock);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_first_of_buffer <= first;
      req_timestamp <= ts;
      req_det_type <= kind;
      req_det_number <= number;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_flush();
      send_word(MODE_FLUSH, 1'($urandom()), TS_W'({$urandom(), $urandom()}),
                TYPE_W'($urandom()), NUM_W'($urandom()));
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outcomes_pending != 0) @(negedge clock);
   endtask

   task automatic set_gap(input logic [GAP_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_gap = value;
   endtask

   // Data word with small detector numbers so detectors fill up
   task automatic send_random_word(input bit opener);
      logic [TYPE_W-1:0] kind;
      logic [NUM_W-1:0]  number;
      logic              first;
      int                span;
      int                r;
      r = $urandom_range(0, 99);
      kind = (r < 90) ? TYPE_W'($urandom_range(0, 5)) : TYPE_W'($urandom_range(6, 7));
      span = detector_count(kind);
      r = $urandom_range(0, 99);
      if (span == 0 || r >= 80)
         number = NUM_W'($urandom());
      else if (r < 60)
         number = NUM_W'($urandom_range(0, (span > 4) ? 3 : span - 1));
      else
         number = NUM_W'($urandom_range(0, span - 1));
      first = opener ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0);
      now_ts = next_ts(opener);
      send_word(MODE_DATA, first, now_ts, kind, number);
   endtask

   // Events of random size, with stray flushes and optional closing flush
   task automatic run_events(input int words);
      int sent;
      int span;
      sent = 0;
      while (sent < words) begin
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (int i = 0; i < span; i++) begin
            if ($urandom_range(0, 99) < 3)
               send_flush();
            else
               send_random_word(i == 0);
         end
         sent += span;
         if ($urandom_range(0, 99) < 40) begin
            send_flush();
            sent++;
         end
      end
   endtask

   // Directed corners at the reset gap of 100
   task automatic directed_words();
      // flush with nothing open
      send_word(MODE_FLUSH, 1'b0, '0, TYPE_LABR, '0);
      // first word opens, then fill one detector past its limit
      for (int k = 0; k < WORDS_PER_DETECTOR + 1; k++)
         send_word(MODE_DATA, 1'b0, TS_W'(10 * k), TYPE_LABR, '0);
      // range edges per type
      send_word(MODE_DATA, 1'b0, TS_W'(50), TYPE_LABR, NUM_W'(LABR_COUNT - 1));
      send_word(MODE_DATA, 1'b0, TS_W'(50), TYPE_LABR, NUM_W'(LABR_COUNT));
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_DE, NUM_W'(DE_COUNT - 1));
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_DE, '1);
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_E, NUM_W'(E_COUNT - 1));
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_GUARD, NUM_W'(GUARD_COUNT));
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_PPAC, NUM_W'(PPAC_COUNT - 1));
      // rf ignores its number
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_RF, NUM_W'(8'hAA));
      // unknown types are ignored but counted
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_OTHER, '0);
      send_word(MODE_DATA, 1'b0, TS_W'(60), TYPE_SPARE, NUM_W'(8'h55));
      // backward step stays in the event
      send_word(MODE_DATA, 1'b0, TS_W'(20), TYPE_DE, NUM_W'(DE_COUNT - 1));
      // step of exactly the gap stays, one more opens
      send_word(MODE_DATA, 1'b0, TS_W'(120), TYPE_RF, '0);
      send_word(MODE_DATA, 1'b0, TS_W'(221), TYPE_LABR, '0);
      // forced start from the buffer flag
      send_word(MODE_DATA, 1'b1, TS_W'(221), TYPE_LABR, '0);
      // timestamp extremes
      send_word(MODE_DATA, 1'b0, '1, TYPE_GUARD, '0);
      send_word(MODE_DATA, 1'b0, '0, TYPE_GUARD, '0);
      // flush closes, second flush finds nothing
      send_word(MODE_FLUSH, 1'b1, '1, TYPE_SPARE, '1);
      send_word(MODE_FLUSH, 1'b0, '0, TYPE_LABR, '0);
      now_ts = '0;
   endtask

   initial begin : stimulus
      logic [GAP_W-1:0] phase_gaps [5];
      phase_gaps[0] = '0;
      phase_gaps[1] = '1;
      phase_gaps[2] = GAP_W'($urandom());
      phase_gaps[3] = GAP_W'(1);
      phase_gaps[4] = GAP_W'($urandom_range(2, 400));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_words();
      run_events(PHASE_WORDS);
      for (int p = 0; p < 5; p++) begin
         set_gap(phase_gaps[p]);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         run_events(PHASE_WORDS);
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outcomes_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tgeb_pkg.sv
hw/rtl/tgeb_fill_store.sv
hw/rtl/time_gap_event_builder_top.sv
dv/tgeb_checker.sv
dv/tb.sv
